@@ hdl/pcm_pkg.sv @@
package pcm_pkg;

  // default widths
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int GAIN_WIDTH_DEF   = 24;

  // fixed widths
  localparam int OUT_W     = 32;
  localparam int LIMIT_W   = 31;
  localparam int MODE_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_SH   = 16;

  // controller forms
  localparam logic [MODE_W-1:0] MODE_INC_PID  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INC_PD   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POS_PID  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POS_PD   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MEAS_PID = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MEAS_PD  = 3'd5;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_KP       = 3'd1,
    REG_KI       = 3'd2,
    REG_KD       = 3'd3,
    REG_LIMIT    = 3'd4
  } cfg_reg_t;

endpackage

@@ hdl/pid_controller_multi_form.sv @@
// Channel   | Dir | Signals                        | Contents
// ----------+-----+--------------------------------+----------------------------------
// s_*       | in  | s_tvalid s_tready s_tdata      | target, feedback_sample
// m_*       | out | m_tvalid m_tready m_tdata/user | drive_value / saturated
// cfg_*     | in  | cfg_wen cfg_index cfg_data     | mode, kp, ki*T/2, kd/T, limit
//
// One sample per cycle sustained while the result stream is not held; a sample waits in
// the input register and its result is registered in the result register. The rate is
// set by the controller state loop: three shared multipliers, the sum, the integrator
// clamp and output saturation all close combinationally between the two registers.
// Reset (rst, synchronous) clears configuration, controller state and both valids.
// While a result waits, one further sample is held in the input register.
module pid_controller_multi_form
  import pcm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int GAIN_WIDTH   = GAIN_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // sample stream
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // [SAMPLE_WIDTH-1:0] target, then feedback_sample, zero padded to bytes
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,
  // result stream
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // [31:0] drive_value
  output logic [OUT_W-1:0]                        m_tdata,
  // [0] saturated
  output logic [0:0]                              m_tuser,
  // configuration writes
  input  logic                                    cfg_wen,
  input  logic [CFG_IDX_W-1:0]                    cfg_index,
  input  logic [((GAIN_WIDTH > LIMIT_W) ? GAIN_WIDTH : LIMIT_W)-1:0] cfg_data
);

  localparam int S         = SAMPLE_WIDTH;
  localparam int G         = GAIN_WIDTH;
  localparam int EW        = S + 1;           // error width
  localparam int XW        = S + 2;           // sample-side multiplier operand
  localparam int GW        = G + 2;           // gain-side multiplier operand
  localparam int PW        = XW + GW;         // full product
  localparam int SUMW_FULL = PW + 2;
  localparam int SUMW      = (SUMW_FULL > 64) ? 64 : SUMW_FULL;
  localparam int QW        = SUMW - FRAC_SH;
  localparam int RW        = ((QW > OUT_W) ? QW : OUT_W) + 2;

  localparam logic signed [RW-1:0] SAT_HI = RW'(2147483647);
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

  // configuration
  logic        [MODE_W-1:0]  mode, mode_next;
  logic signed [G-1:0]       kp, kp_next;
  logic signed [G-1:0]       ki, ki_next;
  logic signed [G-1:0]       kd, kd_next;
  logic        [LIMIT_W-1:0] limit, limit_next;
  logic signed [GW-1:0]      g0, g0_next;      // kp + ki + kd, ki only in incremental PID
  logic signed [GW-1:0]      g1, g1_next;      // ki - kp - 2kd, ki only in incremental PID
  logic signed [G-1:0]       ki_use;

  // controller state
  logic signed [EW-1:0]      last_error;
  logic signed [EW-1:0]      error_before_last;
  logic signed [S-1:0]       last_feedback;
  logic signed [OUT_W-1:0]   integrator;
  logic signed [OUT_W-1:0]   accum;

  // input register
  logic                      in_valid;
  logic signed [EW-1:0]      in_err;
  logic signed [S-1:0]       in_fb;
  logic signed [S-1:0]       sp_in, fb_in;
  logic                      adv;

  // datapath
  logic                      is_inc, is_pos_pid, is_meas, is_ok;
  logic signed [XW-1:0]      bx, cx;
  logic signed [GW-1:0]      ag, bg;
  logic signed [PW-1:0]      prod_a, prod_b, prod_c;
  logic signed [SUMW_FULL-1:0] sum_main_full, sum_int_full;
  logic signed [QW-1:0]      q_main, q_int;
  logic signed [RW-1:0]      integ_sum, integ_new, lim_pos, lim_neg, r_val;
  logic signed [OUT_W-1:0]   drive_next;
  logic                      clip_next;

  // configuration write decode, derived gains formed from the new values
  always_comb begin
    mode_next  = mode;
    kp_next    = kp;
    ki_next    = ki;
    kd_next    = kd;
    limit_next = limit;
    if (cfg_wen) begin
      unique case (cfg_index)
        REG_MODE:  mode_next  = cfg_data[MODE_W-1:0];
        REG_KP:    kp_next    = cfg_data[G-1:0];
        REG_KI:    ki_next    = cfg_data[G-1:0];
        REG_KD:    kd_next    = cfg_data[G-1:0];
        REG_LIMIT: limit_next = cfg_data[LIMIT_W-1:0];
        default:   ;
      endcase
    end
    ki_use  = (mode_next == MODE_INC_PID) ? ki_next : '0;
    g0_next = GW'(kp_next) + GW'(ki_use) + GW'(kd_next);
    g1_next = GW'(ki_use) - GW'(kp_next) - (GW'(kd_next) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= '0;
      kp    <= '0;
      ki    <= '0;
      kd    <= '0;
      limit <= '0;
      g0    <= '0;
      g1    <= '0;
    end else begin
      mode  <= mode_next;
      kp    <= kp_next;
      ki    <= ki_next;
      kd    <= kd_next;
      limit <= limit_next;
      g0    <= g0_next;
      g1    <= g1_next;
    end
  end

  // handshake: input register feeds result register
  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;
  assign sp_in    = s_tdata[S-1:0];
  assign fb_in    = s_tdata[2*S-1:S];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (adv) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // error is formed as the sample is taken
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_err <= EW'(sp_in) - EW'(fb_in);
      in_fb  <= fb_in;
    end
  end

  // form decode
  assign is_inc     = (mode == MODE_INC_PID) || (mode == MODE_INC_PD);
  assign is_pos_pid = (mode == MODE_POS_PID) || (mode == MODE_MEAS_PID);
  assign is_meas    = (mode == MODE_MEAS_PID) || (mode == MODE_MEAS_PD);
  assign is_ok      = (mode <= MODE_MEAS_PD);

  // three shared multipliers, operands chosen by form
  always_comb begin
    ag = is_inc ? g0 : GW'(kp);
    bg = is_inc ? g1 : GW'(ki);
    bx = is_inc ? XW'(last_error) : XW'(in_err) + XW'(last_error);
    if (is_inc) cx = XW'(error_before_last);
    else if (is_meas) cx = XW'(last_feedback) - XW'(in_fb);
    else cx = XW'(in_err) - XW'(last_error);
    prod_a = XW'(in_err) * ag;
    prod_b = bx * bg;
    prod_c = cx * GW'(kd);
  end

  // sums, floor from Q.16 to integer, integrator clamp and output saturation
  always_comb begin
    sum_main_full = SUMW_FULL'(prod_a) + SUMW_FULL'(prod_c)
                  + (is_inc ? SUMW_FULL'(prod_b) : SUMW_FULL'(0));
    sum_int_full  = SUMW_FULL'(prod_b);
    q_main = sum_main_full[SUMW-1:FRAC_SH];
    q_int  = sum_int_full[SUMW-1:FRAC_SH];

    lim_pos   = RW'({1'b0, limit});
    lim_neg   = -lim_pos;
    integ_sum = RW'(integrator) + RW'(q_int);
    if (integ_sum > lim_pos) integ_new = lim_pos;
    else if (integ_sum < lim_neg) integ_new = lim_neg;
    else integ_new = integ_sum;

    if (is_inc) r_val = RW'(accum) + RW'(q_main);
    else r_val = RW'(q_main) + (is_pos_pid ? integ_new : RW'(0));

    clip_next = 1'b0;
    if (!is_ok) begin
      drive_next = accum;
    end else if (r_val > SAT_HI) begin
      drive_next = SAT_HI[OUT_W-1:0];
      clip_next  = 1'b1;
    end else if (r_val < SAT_LO) begin
      drive_next = SAT_LO[OUT_W-1:0];
      clip_next  = 1'b1;
    end else begin
      drive_next = r_val[OUT_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= drive_next;
      m_tuser <= clip_next;
    end
  end

  // controller state update, none for unused codes
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error        <= '0;
      error_before_last <= '0;
      last_feedback     <= '0;
      integrator        <= '0;
      accum             <= '0;
    end else if (adv && is_ok) begin
      last_error <= in_err;
      accum      <= drive_next;
      if (is_inc) error_before_last <= last_error;
      if (is_pos_pid) integrator <= integ_new[OUT_W-1:0];
      if (is_meas) last_feedback <= in_fb;
    end
  end

  // a clipped result sits at one of the rails
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata == 32'h7fffffff || m_tdata == 32'h80000000))
    else $error("saturated result not at a rail");

  // integrator stays within the clamp after a positional PID step
  a_integ_clamp: assert property (@(posedge clk) disable iff (rst)
    adv && is_pos_pid |=>
      ($signed(integrator) <= $signed({2'b0, $past(limit)}) &&
       $signed(integrator) >= -$signed({2'b0, $past(limit)})))
    else $error("integrator outside its limit");

  // input stalls only when the input register is full and the result is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input stalled without a held result");

  // unused codes leave the output accumulator untouched
  a_bad_mode_hold: assert property (@(posedge clk) disable iff (rst)
    adv && !is_ok |=> $stable(accum) && $stable(last_error))
    else $error("state changed on an unused mode");

endmodule
